/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int SCREEN_COLUMNS_DEF = 80;
  localparam int SCREEN_ROWS_DEF    = 25;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = ATTR_W + CHAR_W;
  localparam int POS_W  = 11;

  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h0F;
  localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'h0A;
  localparam logic [CHAR_W-1:0] BACKSPACE_CODE = 8'h08;
  localparam logic [CHAR_W-1:0] NUL_CODE       = 8'h00;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCROLL,
    S_DRAIN,
    S_BLANK,
    S_DONE
  } state_e;

endpackage

/* rtl/tcw_screen_mem.sv */
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: screen cell store, cursor, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// put character, newline, backspace, read and ignored items end in S_DONE; the
//   result is registered once the output is free, and no new item is taken until then
// clear: one cell blanked per cycle
// scroll: one cell copied or blanked per cycle
// after reset a pass blanks every cell of the store; no input is
//   taken meanwhile, attribute writes are
module text_console_writer #(
  parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data_i,

  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [tcw_pkg::MODE_W-1:0] mode_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::POS_W-1:0]  cell_address_i,

  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tcw_pkg::POS_W-1:0]  cursor_position_o,
  output logic [tcw_pkg::CELL_W-1:0] cell_value_o,
  output logic                      scrolled_o
);

  import tcw_pkg::*;

  localparam int CELLS    = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int LAST_ROW = CELLS - SCREEN_COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(CELLS + 1);
  localparam int COL_W    = $clog2(SCREEN_COLUMNS + 1);
  localparam int XW       = (CW > POS_W) ? CW : POS_W;

  state_e              state_q, state_d;
  logic [AW-1:0]       cursor_q, cursor_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic                cp_valid_q, cp_valid_d;
  logic [AW-1:0]       cp_addr_q, cp_addr_d;
  logic                scroll_q, scroll_d;
  logic                read_ok_q, read_ok_d;
  logic [ATTR_W-1:0]   attr_q;

  logic                out_valid_q, out_valid_d;
  logic [POS_W-1:0]    out_cursor_q, out_cursor_d;
  logic [CELL_W-1:0]   out_cell_q, out_cell_d;
  logic                out_scrolled_q, out_scrolled_d;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [CELL_W-1:0]   mem_rdata;

  logic                in_xfer;
  logic                out_free;
  logic [CW-1:0]       nl_next;
  logic [CW-1:0]       ch_next;
  logic [XW-1:0]       addr_ext;
  mode_e               mode;

  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (CELL_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign mode        = mode_e'(mode_i);

  assign nl_next  = CW'(cursor_q) + (CW'(SCREEN_COLUMNS) - CW'(col_q));
  assign ch_next  = CW'(cursor_q) + CW'(1);
  assign addr_ext = XW'(cell_address_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      attr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cursor_q    <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      cp_valid_q  <= 1'b0;
      scroll_q    <= 1'b0;
      read_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      cp_valid_q  <= cp_valid_d;
      scroll_q    <= scroll_d;
      read_ok_q   <= read_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q      <= cp_addr_d;
    out_cursor_q   <= out_cursor_d;
    out_cell_q     <= out_cell_d;
    out_scrolled_q <= out_scrolled_d;
  end

  always_comb begin
    state_d        = state_q;
    cursor_d       = cursor_q;
    col_d          = col_q;
    ptr_d          = ptr_q;
    cp_valid_d     = 1'b0;
    cp_addr_d      = cp_addr_q;
    scroll_d       = scroll_q;
    read_ok_d      = read_ok_q;
    out_cursor_d   = out_cursor_q;
    out_cell_d     = out_cell_q;
    out_scrolled_d = out_scrolled_q;
    out_valid_d    = out_valid_q && out_stall_i;
    mem_we         = 1'b0;
    mem_waddr      = cursor_q;
    mem_wdata      = {attr_q, SPACE_CODE};
    mem_re         = 1'b0;
    mem_raddr      = addr_ext[AW-1:0];

    unique case (state_q)
      S_INIT: begin
        // blank pass after reset uses the reset attribute
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = {ATTR_RESET, SPACE_CODE};
        ptr_d     = ptr_q + AW'(1);
        if (ptr_q == AW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          scroll_d  = 1'b0;
          read_ok_d = 1'b0;
          state_d   = S_DONE;
          case (mode)
            MODE_PUT: begin
              if (char_code_i == NEWLINE_CODE) begin
                col_d = '0;
                if (nl_next == CW'(CELLS)) begin
                  cursor_d = AW'(LAST_ROW);
                  scroll_d = 1'b1;
                  ptr_d    = AW'(SCREEN_COLUMNS);
                  state_d  = S_SCROLL;
                end else begin
                  cursor_d = nl_next[AW-1:0];
                end
              end else if (char_code_i == BACKSPACE_CODE) begin
                if (cursor_q != '0) begin
                  cursor_d  = cursor_q - AW'(1);
                  col_d     = (col_q == '0) ? COL_W'(SCREEN_COLUMNS - 1)
                                            : col_q - COL_W'(1);
                  mem_we    = 1'b1;
                  mem_waddr = cursor_q - AW'(1);
                end
              end else if (char_code_i != NUL_CODE) begin
                mem_we    = 1'b1;
                mem_wdata = {attr_q, char_code_i};
                col_d     = (col_q == COL_W'(SCREEN_COLUMNS - 1)) ? '0
                                                                  : col_q + COL_W'(1);
                if (ch_next == CW'(CELLS)) begin
                  cursor_d = AW'(LAST_ROW);
                  scroll_d = 1'b1;
                  ptr_d    = AW'(SCREEN_COLUMNS);
                  state_d  = S_SCROLL;
                end else begin
                  cursor_d = ch_next[AW-1:0];
                end
              end
            end
            MODE_CLEAR: begin
              cursor_d = '0;
              col_d    = '0;
              ptr_d    = '0;
              state_d  = S_BLANK;
            end
            MODE_READ: begin
              read_ok_d = (addr_ext < XW'(CELLS));
              mem_re    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCROLL: begin
        // read one row below, write it back in the next cycle
        mem_re     = 1'b1;
        mem_raddr  = ptr_q;
        cp_valid_d = 1'b1;
        cp_addr_d  = ptr_q - AW'(SCREEN_COLUMNS);
        mem_we     = cp_valid_q;
        mem_waddr  = cp_addr_q;
        mem_wdata  = mem_rdata;
        ptr_d      = ptr_q + AW'(1);
        if (ptr_q == AW'(CELLS - 1)) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        mem_we    = cp_valid_q;
        mem_waddr = cp_addr_q;
        mem_wdata = mem_rdata;
        ptr_d     = AW'(LAST_ROW);
        state_d   = S_BLANK;
      end

      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        ptr_d     = ptr_q + AW'(1);
        if (ptr_q == AW'(CELLS - 1)) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_cursor_d   = POS_W'(cursor_q);
          out_cell_d     = read_ok_q ? mem_rdata : '0;
          out_scrolled_d = scroll_q;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = out_cursor_q;
  assign cell_value_o      = out_cell_q;
  assign scrolled_o        = out_scrolled_q;

endmodule

/* tb/sv/tb_text_console_writer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A queue of console
// commands feeds a clocked driver; a clocked monitor checks every result
// against a behavioral screen and cursor model kept in the bench. The text
// attribute is set during the reset blank pass, then between phases while idle.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLS            = SCREEN_COLUMNS_DEF;
  localparam int ROWS            = SCREEN_ROWS_DEF;
  localparam int CELL_COUNT      = COLS * ROWS;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int PHASES          = 6;
  localparam int IDLE_LIMIT      = 20000;
  localparam int SETTLE_CYCLES   = CELL_COUNT + 10;

  typedef struct packed {
    mode_e             mode;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  addr;
  } console_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_val;
    logic              scrolled;
  } console_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ATTR_W-1:0] cfg_data_i = '0;

  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [MODE_W-1:0] mode_i = '0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [POS_W-1:0]  cell_address_i = '0;

  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [POS_W-1:0]  cursor_position_o;
  logic [CELL_W-1:0] cell_value_o;
  logic              scrolled_o;

  // screen model
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int                cursor_model;
  logic [ATTR_W-1:0] attr_model;

  console_cmd_t    console_cmds_q[$];
  console_result_t expected_results_q[$];
  console_cmd_t    next_cmd;

  int sent_count    = 0;
  int taken_count   = 0;
  int result_count  = 0;
  int results_seen  = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int error_count   = 0;
  int idle_cycles   = 0;
  int run_left      = 0;

  text_console_writer #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS   (ROWS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .char_code_i      (char_code_i),
    .cell_address_i   (cell_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cursor_position_o(cursor_position_o),
    .cell_value_o     (cell_value_o),
    .scrolled_o       (scrolled_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void blank_from(int first);
    for (int i = first; i < CELL_COUNT; i++) screen_model[i] = {attr_model, SPACE_CODE};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELL_COUNT - COLS; i++) screen_model[i] = screen_model[i + COLS];
    blank_from(CELL_COUNT - COLS);
    cursor_model = (cursor_model >= COLS) ? cursor_model - COLS : 0;
  endfunction

  function automatic console_result_t predict_console(console_cmd_t cmd);
    console_result_t res;
    res = '0;
    if (cursor_model >= CELL_COUNT) cursor_model = 0;
    case (cmd.mode)
      MODE_PUT: begin
        if (cmd.ch == NEWLINE_CODE) begin
          cursor_model += COLS - (cursor_model % COLS);
          if (cursor_model >= CELL_COUNT) begin
            scroll_screen();
            res.scrolled = 1'b1;
          end
        end else if (cmd.ch == BACKSPACE_CODE) begin
          if (cursor_model > 0) begin
            cursor_model--;
            screen_model[cursor_model] = {attr_model, SPACE_CODE};
          end
        end else if (cmd.ch != NUL_CODE) begin
          screen_model[cursor_model] = {attr_model, cmd.ch};
          cursor_model++;
          if (cursor_model >= CELL_COUNT) begin
            scroll_screen();
            res.scrolled = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        blank_from(0);
        cursor_model = 0;
      end
      MODE_READ: begin
        if (cmd.addr < CELL_COUNT) res.cell_val = screen_model[cmd.addr];
      end
      default: ;
    endcase
    res.cursor_pos = cursor_model[POS_W-1:0];
    return res;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic queue_cmd(mode_e mode, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] addr);
    console_cmd_t cmd;
    cmd.mode = mode;
    cmd.ch   = ch;
    cmd.addr = addr;
    console_cmds_q.push_back(cmd);
  endtask

  task automatic wait_drained();
    while (console_cmds_q.size() != 0 || sent_count != taken_count ||
           expected_results_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    attr_model = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // command driver
  always @(negedge clk_i) begin
    if (rst_ni && sent_count == taken_count) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (console_cmds_q.size() > 0) begin
        next_cmd = console_cmds_q.pop_front();
        mode_i         <= next_cmd.mode;
        char_code_i    <= next_cmd.ch;
        cell_address_i <= next_cmd.addr;
        in_valid_i     <= 1'b1;
        sent_count++;
        // every third stretch of 150 commands goes back to back
        gap_left = ((sent_count / 150) % 3 == 2) ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // input transfer: run the model and queue the expected result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results_q.push_back(predict_console('{mode: mode_e'(mode_i),
                                                     ch: char_code_i,
                                                     addr: cell_address_i}));
      taken_count++;
    end
  end

  // result side stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_count != results_seen) begin
        results_seen = result_count;
        stall_left = ((results_seen / 128) % 4 == 1) ? 0 : $urandom_range(0, 7);
      end
      // one long hold-off so the console backs up into its input
      if (!hold_done && result_count >= 300) begin
        hold_done = 1'b1;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    console_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (expected_results_q.size() == 0) begin
        flag_error($sformatf("result with none expected, cursor %0d cell %h",
                             cursor_position_o, cell_value_o));
      end else begin
        want = expected_results_q.pop_front();
        if (cursor_position_o !== want.cursor_pos)
          flag_error($sformatf("cursor_position expected %0d actual %0d",
                               want.cursor_pos, cursor_position_o));
        if (cell_value_o !== want.cell_val)
          flag_error($sformatf("cell_value expected %h actual %h",
                               want.cell_val, cell_value_o));
        if (scrolled_o !== want.scrolled)
          flag_error($sformatf("scrolled expected %b actual %b",
                               want.scrolled, scrolled_o));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    console_cmd_t      cmd;
    int                pick;
    logic [ATTR_W-1:0] attr_plan [PHASES];

    attr_model   = ATTR_RESET;
    cursor_model = 0;
    blank_from(0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_attribute(8'hA5);

    // directed: reads of reset blanks, edges of the address range, ignored codes
    queue_cmd(MODE_READ, 8'h00, 11'd0);
    queue_cmd(MODE_READ, 8'hFF, 11'(CELL_COUNT - 1));
    queue_cmd(MODE_READ, 8'h00, 11'(CELL_COUNT));
    queue_cmd(MODE_READ, 8'hFF, 11'h7FF);
    queue_cmd(MODE_PUT, BACKSPACE_CODE, 11'd0);
    queue_cmd(MODE_PUT, NUL_CODE, 11'h7FF);
    queue_cmd(MODE_NOP, 8'hFF, 11'h7FF);
    queue_cmd(MODE_PUT, 8'h41, 11'd0);
    queue_cmd(MODE_PUT, 8'hFF, 11'd0);
    queue_cmd(MODE_PUT, 8'h01, 11'd0);
    queue_cmd(MODE_PUT, BACKSPACE_CODE, 11'd0);
    queue_cmd(MODE_READ, 8'h00, 11'd1);
    queue_cmd(MODE_READ, 8'h00, 11'd2);
    queue_cmd(MODE_PUT, NEWLINE_CODE, 11'd0);
    // backspace from column zero wraps to the end of the previous row
    queue_cmd(MODE_PUT, BACKSPACE_CODE, 11'd0);
    queue_cmd(MODE_READ, 8'h00, 11'(COLS - 1));
    queue_cmd(MODE_READ, 8'h00, 11'd0);
    queue_cmd(MODE_CLEAR, 8'hFF, 11'h7FF);
    queue_cmd(MODE_READ, 8'h00, 11'd0);
    queue_cmd(MODE_PUT, 8'h7E, 11'd0);
    queue_cmd(MODE_NOP, 8'h00, 11'd0);
    queue_cmd(MODE_READ, 8'h00, 11'd0);
    wait_drained();

    attr_plan[0] = 8'h00;
    attr_plan[1] = ATTR_W'($urandom_range(0, 255));
    attr_plan[2] = 8'hFF;
    attr_plan[3] = ATTR_W'($urandom_range(0, 255));
    attr_plan[4] = ATTR_RESET;
    attr_plan[5] = ATTR_W'($urandom_range(0, 255));

    for (int phase = 0; phase < PHASES; phase++) begin
      write_attribute(attr_plan[phase]);
      repeat (ITEMS_PER_PHASE) begin
        cmd.mode = MODE_PUT;
        cmd.ch   = CHAR_W'($urandom_range(0, 255));
        cmd.addr = POS_W'($urandom_range(0, 2047));
        if (run_left > 0) begin
          // long run with no newline, backspace or NUL, may wrap rows and scroll off the bottom
          run_left--;
          if (cmd.ch == NEWLINE_CODE || cmd.ch == BACKSPACE_CODE || cmd.ch == NUL_CODE)
            cmd.ch = 8'h2A;
        end else begin
          pick = $urandom_range(0, 249);
          if (pick == 0) begin
            run_left = $urandom_range(60, 130);
          end else if (pick == 1) begin
            cmd.mode = MODE_CLEAR;
          end else if (pick < 7) begin
            cmd.mode = MODE_NOP;
          end else if (pick < 37) begin
            cmd.mode = MODE_READ;
            cmd.addr = POS_W'(($urandom_range(0, 7) == 0)
                              ? $urandom_range(CELL_COUNT, 2047)
                              : $urandom_range(0, CELL_COUNT - 1));
          end else if (pick < 87) begin
            cmd.ch = NEWLINE_CODE;
          end else if (pick < 102) begin
            cmd.ch = BACKSPACE_CODE;
          end else if (pick < 107) begin
            cmd.ch = NUL_CODE;
          end
        end
        console_cmds_q.push_back(cmd);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
